[sv/bounded_integer_set_table_unit_defines.svh]
// Assertion macros for the bounded integer set table unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_INTEGER_SET_TABLE_UNIT_DEFINES_SVH
`define BOUNDED_INTEGER_SET_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BIST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bist assertion failed");
`define BIST_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("bist assertion failed");
`else
`define BIST_ASSERT(label, clk, rst, prop)
`define BIST_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif
`endif

[sv/bist_pkg.sv]
// Shared types, constants and helpers for the bounded integer set table unit.
// No dependencies; used by bist_cell and the top level.
`timescale 1ns / 1ps
package bist_pkg;

   localparam int CAPACITY = 128;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int FUNC_W   = 2;
   localparam int RSP_W    = 16;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [FUNC_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY
   } state_type;

   // per-cell command from the sequencer
   typedef struct packed {
      logic capture;
      logic load;
      logic shift;
   } cell_ctrl_type;

   // bit i set when any bit 0..i of v is set
   function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
      logic [CAPACITY-1:0] r;
      r = v;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         r = r | (r << s);
      end
      return r;
   endfunction

endpackage

[sv/bounded_integer_set_table_unit.sv]
// Bounded integer set table: a row of CAPACITY compare/shift cells.
// Request registered on accept; matches captured in ST_MATCH; response registered
// in ST_APPLY (held while rsp stalls). New requests accepted only back in ST_IDLE.
// Remove compacts all later entries at once, when apply_go fires, via neighbor shift.
// Reset (sync, active high) empties the set; entry storage itself is not cleared.
`timescale 1ns / 1ps
`include "bounded_integer_set_table_unit_defines.svh"
module bounded_integer_set_table_unit
   import bist_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VAL_W-1:0]   req_tdata,   // [31:0] item_value
   input  logic [FUNC_W-1:0]  req_tuser,   // [1:0] func
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata    // [0] was_member, [1] changed,
                                           // [9:2] live_count, [10] is_empty,
                                           // [11] is_full, [15:12] zero
);

   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [VAL_W-1:0]  key_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic              capture;
   logic              apply_go;
   logic              member;
   logic              member_out;
   logic              changed;
   logic              ins_go;
   logic              rem_go;

   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] shift_vec;
   logic [VAL_W-1:0]    entry_vec [CAPACITY];

   assign req_fire = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_MATCH;
         ST_MATCH: state_in = ST_APPLY;
         ST_APPLY: if (apply_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      capture    = 1'b0;
      apply_go   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_MATCH: capture    = 1'b1;
         ST_APPLY: apply_go   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= op_type'(req_tuser);
         key_ff <= req_tdata;
      end
   end

   // values are distinct, so at most one cell matches
   assign member    = |match_vec;
   assign shift_vec = prefix_or(match_vec);

   always_comb begin
      count_in   = count_ff;
      member_out = member;
      changed    = 1'b0;
      ins_go     = 1'b0;
      rem_go     = 1'b0;
      unique case (op_ff)
         OP_INSERT: begin
            if (!member && (count_ff < CAP_CNT)) begin
               ins_go   = 1'b1;
               changed  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (member) begin
               rem_go   = 1'b1;
               changed  = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_LOOKUP: ;
         OP_CLEAR: begin
            count_in   = '0;
            member_out = 1'b0;
            changed    = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = member_out;
      rsp_data_in[1]     = changed;
      rsp_data_in[9:2]   = 8'(count_in);
      rsp_data_in[10]    = (count_in == '0);
      rsp_data_in[11]    = (count_in == CAP_CNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (apply_go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (apply_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CNT_W-1:0] CellIdx = CNT_W'(i);
      cell_ctrl_type     ctrl;
      logic [VAL_W-1:0]  next_entry;

      assign ctrl.capture = capture;
      assign ctrl.load    = apply_go && ins_go && (count_ff == CellIdx);
      assign ctrl.shift   = apply_go && rem_go && shift_vec[i];

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = entry_vec[i];
      end else begin : g_mid
         assign next_entry = entry_vec[i+1];
      end

      bist_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .live       (CellIdx < count_ff),
         .key        (key_ff),
         .next_entry (next_entry),
         .entry      (entry_vec[i]),
         .match      (match_vec[i])
      );
   end

   `BIST_ASSERT(a_count_bound, clock, reset, count_ff <= CAP_CNT)
   `BIST_ASSERT(a_single_match, clock, reset, (state_ff != ST_APPLY) || $onehot0(match_vec))
   `BIST_ASSERT(a_rsp_count, clock, reset, !rsp_valid_ff || (rsp_data_ff[9:2] == 8'(count_ff)))
   `BIST_ASSERT_NEXT(a_clear_empties, clock, reset, apply_go && (op_ff == OP_CLEAR), count_ff == '0)
   `BIST_ASSERT_NEXT(a_insert_grows, clock, reset, apply_go && (op_ff == OP_INSERT), count_ff >= $past(count_ff))

endmodule

[sv/bist_cell.sv]
// One storage cell of the set table: holds one entry and its match flag.
// Depends on bist_pkg; takes its neighbor's entry for compaction.
`timescale 1ns / 1ps
module bist_cell
   import bist_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic               live,
   input  logic [VAL_W-1:0]   key,
   input  logic [VAL_W-1:0]   next_entry,
   output logic [VAL_W-1:0]   entry,
   output logic               match
);

   logic [VAL_W-1:0] entry_ff;
   logic             match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctrl.capture) begin
         match_ff <= live && (entry_ff == key);
      end
   end

   // load and shift never coincide: one comes from insert, the other from remove
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         entry_ff <= key;
      end else if (ctrl.shift) begin
         entry_ff <= next_entry;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule
